// ===== design/bcc_pkg.sv =====
package bcc_pkg;

  // click machine states, one-hot
  typedef enum logic [6:0] {
    ST_WAIT_PUSH      = 7'b0000001,
    ST_WAIT_RELEASE   = 7'b0000010,
    ST_WAIT_SECOND    = 7'b0000100,
    ST_WAIT_SECOND_UP = 7'b0001000,
    ST_DOUBLE_DELAY   = 7'b0010000,
    ST_TIMEOUT        = 7'b0100000,
    ST_WAIT_FINAL_UP  = 7'b1000000
  } click_state_t;

  localparam int unsigned WINDOW_W = 8;
  localparam int unsigned COUNT_W  = WINDOW_W + 1;

  // event flags of one result
  typedef struct packed {
    logic push;
    logic release_ev;
    logic long_ev;
    logic double_ev;
    logic irq;
  } click_events_t;

endpackage

// ===== design/button_click_classifier_unit.sv =====
// channel  | direction | handshake             | payload
// ---------+-----------+-----------------------+---------------------------------------------
// in_      | input     | in_valid / in_ready   | in_switch_level
// out_     | output    | out_valid / out_ready | out_ev_push, out_ev_release, out_ev_long,
//          |           |                       | out_ev_double, out_irq_pulse
// cfg_     | input     | cfg_wr_en             | cfg_wr_data (click window)
//
// one tick per transaction: the state update is a single pass of compare and count logic, so
// a new transaction is taken every cycle in_ready is high, its result in the next cycle.
// rst_n is synchronous, active low; it clears the state machine, counters, window register
// and the output valid.
// the output register frees in the cycle it is taken, so in_ready only drops while a result
// waits and out_ready is low.
module button_click_classifier_unit #(
  parameter int unsigned DEBOUNCE_TICKS = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_switch_level,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_ev_push,
  output logic                         out_ev_release,
  output logic                         out_ev_long,
  output logic                         out_ev_double,
  output logic                         out_irq_pulse,
  input  logic                         cfg_wr_en,
  input  logic [bcc_pkg::WINDOW_W-1:0] cfg_wr_data
);

  localparam int unsigned BW = $clog2(DEBOUNCE_TICKS + 1);
  localparam logic [BW-1:0] DT_B = BW'(DEBOUNCE_TICKS);

  bcc_pkg::click_state_t state_r, state_nxt;
  logic [BW-1:0] bounce_r, bounce_nxt;
  logic filt_r, filt_nxt;
  logic [bcc_pkg::COUNT_W-1:0] window_cnt_r, window_cnt_nxt;
  logic [bcc_pkg::COUNT_W-1:0] lockout_cnt_r, lockout_cnt_nxt;
  logic [bcc_pkg::WINDOW_W-1:0] click_window_r;
  bcc_pkg::click_events_t ev_nxt, ev_r;
  logic out_valid_r;

  logic in_fire;
  logic expire;
  logic [BW-1:0] bounce_s;
  logic filt_s;
  logic [bcc_pkg::COUNT_W-1:0] window_ext;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // debounce step on the raw level
  always_comb begin
    bounce_s = bounce_r;
    filt_s   = filt_r;
    if (!in_switch_level) begin
      if (bounce_r >= DT_B) begin
        bounce_s = DT_B;
        filt_s   = 1'b1;
      end else begin
        bounce_s = bounce_r + BW'(1);
      end
    end else begin
      if (bounce_r == '0) begin
        filt_s = 1'b0;
      end else begin
        bounce_s = bounce_r - BW'(1);
      end
    end
  end

  assign window_ext = {1'b0, click_window_r};
  assign expire     = window_cnt_r > window_ext;

  // click state machine for one tick
  always_comb begin
    bcc_pkg::click_state_t st;
    st              = state_r;
    bounce_nxt      = bounce_r;
    filt_nxt        = filt_r;
    window_cnt_nxt  = window_cnt_r;
    lockout_cnt_nxt = lockout_cnt_r;
    ev_nxt          = '0;
    state_nxt       = state_r;

    if (expire) begin
      st = bcc_pkg::ST_TIMEOUT;
    end else begin
      window_cnt_nxt = window_cnt_r + bcc_pkg::COUNT_W'(1);
    end

    unique case (st)
      bcc_pkg::ST_WAIT_RELEASE: begin
        bounce_nxt = bounce_s;
        filt_nxt   = filt_s;
        if (!filt_s) state_nxt = bcc_pkg::ST_WAIT_SECOND;
      end
      bcc_pkg::ST_WAIT_SECOND: begin
        bounce_nxt = bounce_s;
        filt_nxt   = filt_s;
        if (filt_s) state_nxt = bcc_pkg::ST_WAIT_SECOND_UP;
      end
      bcc_pkg::ST_WAIT_SECOND_UP: begin
        bounce_nxt = bounce_s;
        filt_nxt   = filt_s;
        if (!filt_s) begin
          window_cnt_nxt   = '0;
          lockout_cnt_nxt  = '0;
          state_nxt        = bcc_pkg::ST_DOUBLE_DELAY;
          ev_nxt.double_ev = 1'b1;
          ev_nxt.irq       = 1'b1;
        end
      end
      bcc_pkg::ST_DOUBLE_DELAY: begin
        // switch not sampled during lockout
        window_cnt_nxt = '0;
        if (lockout_cnt_r > window_ext) begin
          state_nxt = bcc_pkg::ST_WAIT_PUSH;
        end else begin
          lockout_cnt_nxt = lockout_cnt_r + bcc_pkg::COUNT_W'(1);
        end
      end
      bcc_pkg::ST_TIMEOUT: begin
        bounce_nxt     = bounce_s;
        filt_nxt       = filt_s;
        window_cnt_nxt = '0;
        ev_nxt.push    = 1'b1;
        ev_nxt.irq     = 1'b1;
        if (filt_s) begin
          state_nxt      = bcc_pkg::ST_WAIT_FINAL_UP;
          ev_nxt.long_ev = (click_window_r != '0);
        end else begin
          state_nxt         = bcc_pkg::ST_WAIT_PUSH;
          ev_nxt.release_ev = 1'b1;
        end
      end
      bcc_pkg::ST_WAIT_FINAL_UP: begin
        bounce_nxt     = bounce_s;
        filt_nxt       = filt_s;
        window_cnt_nxt = '0;
        if (!filt_s) begin
          ev_nxt.release_ev = 1'b1;
          ev_nxt.irq        = 1'b1;
          state_nxt         = bcc_pkg::ST_WAIT_PUSH;
        end
      end
      default: begin
        // wait for push, also covers any stray code
        bounce_nxt     = bounce_s;
        filt_nxt       = filt_s;
        window_cnt_nxt = '0;
        state_nxt      = filt_s ? bcc_pkg::ST_WAIT_RELEASE : bcc_pkg::ST_WAIT_PUSH;
      end
    endcase
  end

  // state and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= bcc_pkg::ST_WAIT_PUSH;
      bounce_r       <= '0;
      filt_r         <= 1'b0;
      window_cnt_r   <= '0;
      lockout_cnt_r  <= '0;
      click_window_r <= '0;
    end else begin
      if (cfg_wr_en) click_window_r <= cfg_wr_data;
      if (in_fire) begin
        state_r       <= state_nxt;
        bounce_r      <= bounce_nxt;
        filt_r        <= filt_nxt;
        window_cnt_r  <= window_cnt_nxt;
        lockout_cnt_r <= lockout_cnt_nxt;
      end
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_valid;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_fire) ev_r <= ev_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_ev_push    = ev_r.push;
  assign out_ev_release = ev_r.release_ev;
  assign out_ev_long    = ev_r.long_ev;
  assign out_ev_double  = ev_r.double_ev;
  assign out_irq_pulse  = ev_r.irq;

  // interrupt tracks the event flags
  a_irq_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (ev_r.irq == (ev_r.push || ev_r.release_ev || ev_r.long_ev ||
                                  ev_r.double_ev)))
    else $error("irq does not match event flags");

  // a double push never comes with a timeout report
  a_double_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && ev_r.double_ev |-> !ev_r.push && !ev_r.release_ev && !ev_r.long_ev)
    else $error("double push reported with other events");

  // debounce counter stays within its limit
  a_bounce_range: assert property (@(posedge clk) disable iff (!rst_n)
    bounce_r <= DT_B)
    else $error("debounce counter out of range");

  // the window is idle while waiting for a push or during lockout
  a_window_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bcc_pkg::ST_WAIT_PUSH || state_r == bcc_pkg::ST_DOUBLE_DELAY)
      |-> window_cnt_r == '0)
    else $error("window counter running in idle state");

  // every accepted transaction yields a result next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted transaction produced no result");

endmodule
